// ===== rtl/core/vup_pkg.sv =====
// ----------------------------------------------------------------------------
// vup_pkg
// Shared types, register codes and constants of the vertex UV projection.
// ----------------------------------------------------------------------------
package vup_pkg;

  // projection modes
  localparam logic [1:0] MODE_PLANAR = 2'd0;
  localparam logic [1:0] MODE_BOX    = 2'd1;
  localparam logic [1:0] MODE_SPHERE = 2'd2;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_MODE     = 2'd0;
  localparam logic [1:0] REG_SCALE    = 2'd1;
  localparam logic [1:0] REG_OFFSET_U = 2'd2;
  localparam logic [1:0] REG_OFFSET_V = 2'd3;

  localparam int VEC_W = 36;  // CORDIC vector component width
  localparam int ANG_W = 35;  // angle width, radians Q2.30

  localparam logic signed [ANG_W-1:0] PI_Q30     = 35'sd3373259426;
  localparam logic signed [32:0]      INV_PI_Q32 = 33'sd1367130551;

  // one step of the digit-by-digit square root
  typedef struct packed {
    logic [63:0] rad;   // radicand bits not yet consumed, top first
    logic [33:0] rem;   // partial remainder
    logic [31:0] root;  // partial root
  } sqrt_t;

  // one CORDIC vector in flight
  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ANG_W-1:0] ang;
    logic                    zero;  // vector was (0, 0): angle is 0
  } vec_t;

  // per-vertex data that rides alongside the arithmetic chains
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               sph;   // take the spherical result
    logic signed [31:0] pl_u;  // planar or box result
    logic signed [31:0] pl_v;
  } side_t;

  // arctangent of 2^-i in Q2.30, rounded to nearest
  function automatic logic signed [ANG_W-1:0] atan_entry(input int unsigned i);
    logic signed [ANG_W-1:0] r;
    case (i)
      0:       r = 35'sd843314857;
      1:       r = 35'sd497837829;
      2:       r = 35'sd263043837;
      3:       r = 35'sd133525159;
      4:       r = 35'sd67021687;
      5:       r = 35'sd33543516;
      6:       r = 35'sd16775851;
      7:       r = 35'sd8388437;
      8:       r = 35'sd4194283;
      9:       r = 35'sd2097149;
      10:      r = 35'sd1048576;
      default: begin
        if (i <= 30) begin
          r = ANG_W'(longint'(1) << (30 - i));
        end else begin
          r = '0;
        end
      end
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/vup_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// vup_sqrt_cell
// One result bit of the floor square root; cells chain into a full root.
// ----------------------------------------------------------------------------
module vup_sqrt_cell (
  input  logic           clk,
  input  logic           en,
  input  vup_pkg::sqrt_t din,
  output vup_pkg::sqrt_t dout
);

  logic [35:0] cand;
  logic [35:0] trial;
  logic [35:0] diff;
  logic        take;

  // bring in two radicand bits and try the next root bit
  always_comb begin
    cand  = {din.rem, din.rad[63:62]};
    trial = {2'b00, din.root, 2'b01};
    diff  = cand - trial;
    take  = (cand >= trial);
  end

  // advance one bit
  always_ff @(posedge clk) begin
    if (en) begin
      dout.rad  <= {din.rad[61:0], 2'b00};
      dout.rem  <= take ? diff[33:0] : cand[33:0];
      dout.root <= {din.root[30:0], take};
    end
  end

endmodule

// ===== rtl/core/vup_norm_cell.sv =====
// ----------------------------------------------------------------------------
// vup_norm_cell
// One stage of the CORDIC input normalizer: shifts up by a fixed power of two.
// ----------------------------------------------------------------------------
module vup_norm_cell #(
  parameter int SHIFT = 16
) (
  input  logic          clk,
  input  logic          en,
  input  vup_pkg::vec_t din,
  output vup_pkg::vec_t dout
);

  logic signed [vup_pkg::VEC_W-1:0] ay;
  logic signed [vup_pkg::VEC_W-1:0] mag;
  logic                             small_mag;

  // shift when the larger magnitude stays below 2^32 after the shift
  always_comb begin
    ay        = (din.y < 0) ? -din.y : din.y;
    mag       = (din.x > ay) ? din.x : ay;
    small_mag = ((mag >>> (32 - SHIFT)) == 0) && !din.zero;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.x    <= small_mag ? (din.x <<< SHIFT) : din.x;
      dout.y    <= small_mag ? (din.y <<< SHIFT) : din.y;
      dout.ang  <= din.ang;
      dout.zero <= din.zero;
    end
  end

endmodule

// ===== rtl/core/vup_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// vup_cordic_cell
// One vectoring-mode CORDIC rotation; cells chain into an atan2 unit.
// ----------------------------------------------------------------------------
module vup_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          en,
  input  vup_pkg::vec_t din,
  output vup_pkg::vec_t dout
);

  localparam logic signed [vup_pkg::ANG_W-1:0] ATAN = vup_pkg::atan_entry(STEP);

  logic signed [vup_pkg::VEC_W-1:0] dx;
  logic signed [vup_pkg::VEC_W-1:0] dy;

  always_comb begin
    dx = din.y >>> STEP;
    dy = din.x >>> STEP;
  end

  // rotate toward the x axis, accumulate the angle
  always_ff @(posedge clk) begin
    if (en) begin
      if (din.y >= 0) begin
        dout.x   <= din.x + dx;
        dout.y   <= din.y - dy;
        dout.ang <= din.ang + ATAN;
      end else begin
        dout.x   <= din.x - dx;
        dout.y   <= din.y + dy;
        dout.ang <= din.ang - ATAN;
      end
      dout.zero <= din.zero;
    end
  end

endmodule

// ===== rtl/core/vertex_uv_projection.sv =====
// ----------------------------------------------------------------------------
// vertex_uv_projection
// Planar, box or spherical texture coordinates for a stream of vertices.
// ----------------------------------------------------------------------------
// Takes one vertex request per cycle while the output is not blocked and
// returns one (tex_u, tex_v) request per vertex, in order. Each request
// passes the 32-cell square root chain followed by the two CORDIC chains
// (normalizer plus one cell per iteration) that run side by side for u
// and v, on its way to the output register. All modes take the same path,
// so the order never changes. The output register holds a finished
// request while the pipeline keeps filling its empty slots.
module vertex_uv_projection #(
  parameter int CORDIC_STEPS = 20
) (
  input  logic         clk,
  input  logic         rst,
  // stream in
  input  logic         s_tvalid,
  output logic         s_tready,
  // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z,
  // [111:96] norm_x, [127:112] norm_y, [143:128] norm_z
  input  logic [143:0] s_tdata,
  // stream out
  output logic         m_tvalid,
  input  logic         m_tready,
  // [31:0] tex_u, [63:32] tex_v
  output logic [63:0]  m_tdata,
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int ST     = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  localparam int NSQ    = 32;
  localparam int NNRM   = 5;
  localparam int K_SQ   = 2;
  localparam int K_PREP = K_SQ + NSQ + 1;
  localparam int K_CLMP = K_PREP + NNRM + ST + 1;
  localparam int K_MUL  = K_CLMP + 1;
  localparam int K_CRD  = K_MUL + 1;
  localparam int D      = K_CRD + 2;

  // configuration registers
  logic [1:0]         mode;
  logic [30:0]        scale;
  logic signed [31:0] offset_u;
  logic signed [31:0] offset_v;

  logic wr;
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= vup_pkg::MODE_PLANAR;
      scale    <= 31'd65536;
      offset_u <= '0;
      offset_v <= '0;
    end else if (wr) begin
      case (paddr[3:2])
        vup_pkg::REG_MODE:     mode     <= pwdata[1:0];
        vup_pkg::REG_SCALE:    scale    <= pwdata[30:0];
        vup_pkg::REG_OFFSET_U: offset_u <= pwdata;
        vup_pkg::REG_OFFSET_V: offset_v <= pwdata;
        default:               mode     <= mode;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      vup_pkg::REG_MODE:     prdata = {30'd0, mode};
      vup_pkg::REG_SCALE:    prdata = {1'b0, scale};
      vup_pkg::REG_OFFSET_U: prdata = offset_u;
      vup_pkg::REG_OFFSET_V: prdata = offset_v;
      default:               prdata = '0;
    endcase
  end

  // flow control: pipeline moves unless its last stage is blocked
  logic [D-1:0] vld;
  logic         adv;
  logic         o_load;

  assign adv      = !vld[D-1] || !m_tvalid || m_tready;
  assign s_tready = adv;
  assign o_load   = vld[D-1] && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[D-2:0], s_tvalid};
    end
  end

  // input decode: planar or box pick, spherical flag
  logic signed [31:0] in_x, in_y, in_z;
  logic signed [15:0] in_nx, in_ny, in_nz;
  logic signed [16:0] ax, ay, az;
  vup_pkg::side_t     side_in;

  always_comb begin
    in_x  = s_tdata[31:0];
    in_y  = s_tdata[63:32];
    in_z  = s_tdata[95:64];
    in_nx = s_tdata[111:96];
    in_ny = s_tdata[127:112];
    in_nz = s_tdata[143:128];
    ax    = (in_nx < 0) ? -17'(in_nx) : 17'(in_nx);
    ay    = (in_ny < 0) ? -17'(in_ny) : 17'(in_ny);
    az    = (in_nz < 0) ? -17'(in_nz) : 17'(in_nz);
    side_in.x    = in_x;
    side_in.y    = in_y;
    side_in.z    = in_z;
    side_in.sph  = (mode == vup_pkg::MODE_SPHERE) &&
                   ((in_x != 0) || (in_y != 0) || (in_z != 0));
    side_in.pl_u = in_x;
    side_in.pl_v = in_z;
    if (mode == vup_pkg::MODE_BOX) begin
      if ((ax >= ay) && (ax >= az)) begin
        side_in.pl_u = in_z;
        side_in.pl_v = in_y;
      end else if (ay >= az) begin
        side_in.pl_u = in_x;
        side_in.pl_v = in_z;
      end else begin
        side_in.pl_u = in_x;
        side_in.pl_v = in_y;
      end
    end
  end

  // sideband delay line, one entry per stage
  vup_pkg::side_t side_q [D];

  always_ff @(posedge clk) begin
    if (adv) begin
      side_q[0] <= side_in;
      for (int k = 1; k < D; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // radicand x*x + z*z
  logic [63:0] xx, zz, sq;

  always_ff @(posedge clk) begin
    if (adv) begin
      xx <= 64'(side_q[0].x * side_q[0].x);
      zz <= 64'(side_q[0].z * side_q[0].z);
      sq <= xx + zz;
    end
  end

  // square root chain
  vup_pkg::sqrt_t sq_chain [NSQ+1];

  assign sq_chain[0] = '{rad: sq, rem: '0, root: '0};

  for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
    vup_sqrt_cell u_cell (
      .clk  (clk),
      .en   (adv),
      .din  (sq_chain[j]),
      .dout (sq_chain[j+1])
    );
  end

  // turn by pi for a negative x operand
  function automatic vup_pkg::vec_t prep_vec(input logic signed [32:0] yi,
                                             input logic signed [32:0] xi);
    vup_pkg::vec_t r;
    r.zero = (xi == 0) && (yi == 0);
    if (xi < 0) begin
      r.x   = -vup_pkg::VEC_W'(xi);
      r.y   = -vup_pkg::VEC_W'(yi);
      r.ang = (yi >= 0) ? vup_pkg::PI_Q30 : -vup_pkg::PI_Q30;
    end else begin
      r.x   = vup_pkg::VEC_W'(xi);
      r.y   = vup_pkg::VEC_W'(yi);
      r.ang = '0;
    end
    return r;
  endfunction

  vup_pkg::vec_t vu [NNRM+ST+1];
  vup_pkg::vec_t vv [NNRM+ST+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      vu[0] <= prep_vec(33'(side_q[K_PREP-1].z), 33'(side_q[K_PREP-1].x));
      vv[0] <= prep_vec(33'(side_q[K_PREP-1].y), $signed({1'b0, sq_chain[NSQ].root}));
    end
  end

  // normalizer chains
  for (genvar n = 0; n < NNRM; n++) begin : g_norm
    vup_norm_cell #(.SHIFT(16 >> n)) u_norm_u (
      .clk (clk), .en (adv), .din (vu[n]), .dout (vu[n+1])
    );
    vup_norm_cell #(.SHIFT(16 >> n)) u_norm_v (
      .clk (clk), .en (adv), .din (vv[n]), .dout (vv[n+1])
    );
  end

  // CORDIC chains
  for (genvar i = 0; i < ST; i++) begin : g_cordic
    vup_cordic_cell #(.STEP(i)) u_cord_u (
      .clk (clk), .en (adv), .din (vu[NNRM+i]), .dout (vu[NNRM+i+1])
    );
    vup_cordic_cell #(.STEP(i)) u_cord_v (
      .clk (clk), .en (adv), .din (vv[NNRM+i]), .dout (vv[NNRM+i+1])
    );
  end

  // clamp angles to [-pi, pi], force zero vectors to angle 0
  function automatic logic signed [vup_pkg::ANG_W-1:0] clamp_ang(input vup_pkg::vec_t v);
    logic signed [vup_pkg::ANG_W-1:0] r;
    if (v.zero) begin
      r = '0;
    end else if (v.ang > vup_pkg::PI_Q30) begin
      r = vup_pkg::PI_Q30;
    end else if (v.ang < -vup_pkg::PI_Q30) begin
      r = -vup_pkg::PI_Q30;
    end else begin
      r = v.ang;
    end
    return r;
  endfunction

  logic signed [vup_pkg::ANG_W-1:0] ang_u, ang_v;
  logic signed [67:0]               prod_u, prod_v;
  logic signed [31:0]               crd_u, crd_v;
  logic signed [31:0]               sph_u, sph_v;
  logic signed [63:0]               mul_u, mul_v;

  always_comb begin
    sph_u = 32'((prod_u + (68'sd1 <<< 46)) >>> 47) + 32'sd32768;
    sph_v = 32'((prod_v + (68'sd1 <<< 45)) >>> 46) + 32'sd32768;
  end

  // angle to Q16.16 coordinate, select, then scale
  always_ff @(posedge clk) begin
    if (adv) begin
      ang_u  <= clamp_ang(vu[NNRM+ST]);
      ang_v  <= clamp_ang(vv[NNRM+ST]);
      prod_u <= ang_u * vup_pkg::INV_PI_Q32;
      prod_v <= ang_v * vup_pkg::INV_PI_Q32;
      crd_u  <= side_q[K_CRD-1].sph ? sph_u : side_q[K_CRD-1].pl_u;
      crd_v  <= side_q[K_CRD-1].sph ? sph_v : side_q[K_CRD-1].pl_v;
      mul_u  <= crd_u * $signed({1'b0, scale});
      mul_v  <= crd_v * $signed({1'b0, scale});
    end
  end

  // round, offset and saturate into the output register
  function automatic logic signed [31:0] finish(input logic signed [63:0] m,
                                                input logic signed [31:0] off);
    logic signed [48:0] r;
    r = 49'((m + 64'sd32768) >>> 16) + 49'(off);
    if (r > 49'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (r < -49'sd2147483648) begin
      return 32'sh80000000;
    end
    return 32'(r);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (o_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      m_tdata <= {finish(mul_v, offset_v), finish(mul_u, offset_u)};
    end
  end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// vertex_uv_projection testbench
// Streams vertices through the projection under every mode and several
// scale and offset settings, and checks each (tex_u, tex_v) against a
// bit-exact predictor of the planar, box and CORDIC-based spherical paths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int STEPS    = 20;
  localparam int LATENCY  = 45 + STEPS + 4;
  localparam int WATCHDOG = 20000;
  localparam longint PI_Q30_L  = 64'sd3373259426;
  localparam longint INV_PI_L  = 64'sd1367130551;

  typedef struct packed {
    logic signed [15:0] nz;
    logic signed [15:0] ny;
    logic signed [15:0] nx;
    logic signed [31:0] z;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } vertex_t;

  // ---------------------------------------------------------------------------
  // UV predictor and store of expected coordinates
  // ---------------------------------------------------------------------------
  class uv_scoreboard;
    logic [1:0]  mode;
    logic [30:0] scale;
    longint      off_u, off_v;
    logic [63:0] pending_uv[$];
    int          mismatches;
    int          checked;

    function new();
      mode = vup_pkg::MODE_PLANAR; scale = 31'd65536; off_u = 0; off_v = 0;
      mismatches = 0; checked = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        vup_pkg::REG_MODE:     mode = val[1:0];
        vup_pkg::REG_SCALE:    scale = val[30:0];
        vup_pkg::REG_OFFSET_U: off_u = longint'($signed(val));
        vup_pkg::REG_OFFSET_V: off_v = longint'($signed(val));
        default: ;
      endcase
    endfunction

    function longint isqrt(longint unsigned n);
      longint unsigned root, bit_v;
      root = 0; bit_v = 64'd1 << 62;
      while (bit_v > n) bit_v >>= 2;
      while (bit_v != 0) begin
        if (n >= root + bit_v) begin
          n -= root + bit_v;
          root = (root >> 1) + bit_v;
        end else begin
          root >>= 1;
        end
        bit_v >>= 2;
      end
      return longint'(root);
    endfunction

    function longint arctan_entry(int i);
      longint tbl[11];
      tbl = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
              16775851, 8388437, 4194283, 2097149, 1048576};
      if (i < 11) return tbl[i];
      if (i <= 30) return longint'(1) << (30 - i);
      return 0;
    endfunction

    // vectoring CORDIC, angle in Q2.30
    function longint vector_angle(longint y, longint x);
      longint ang, mag, ay, dx, dy;
      ang = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        ang = (y >= 0) ? PI_Q30_L : -PI_Q30_L;
        x = -x; y = -y;
      end
      ay = y < 0 ? -y : y;
      mag = x > ay ? x : ay;
      while (mag < (longint'(1) << 31)) begin
        x *= 2; y *= 2; mag *= 2;
      end
      for (int i = 0; i < STEPS; i++) begin
        dx = y >>> i; dy = x >>> i;
        if (y >= 0) begin
          x += dx; y -= dy; ang += arctan_entry(i);
        end else begin
          x -= dx; y += dy; ang -= arctan_entry(i);
        end
      end
      if (ang > PI_Q30_L) ang = PI_Q30_L;
      if (ang < -PI_Q30_L) ang = -PI_Q30_L;
      return ang;
    endfunction

    function logic [31:0] scale_offset(longint c, longint off);
      longint r;
      r = ((c * longint'({33'd0, scale}) + (longint'(1) << 15)) >>> 16) + off;
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r[31:0];
    endfunction

    function void note_vertex(vertex_t vx);
      longint x, y, z, u, v, ax, ay, az, r;
      x = vx.x; y = vx.y; z = vx.z;
      u = x; v = z;
      if (mode == vup_pkg::MODE_SPHERE) begin
        if (x != 0 || y != 0 || z != 0) begin
          r = isqrt(longint'(x * x) + longint'(z * z));
          u = ((vector_angle(z, x) * INV_PI_L + (longint'(1) << 46)) >>> 47) + 32768;
          v = ((vector_angle(y, r) * INV_PI_L + (longint'(1) << 45)) >>> 46) + 32768;
        end
      end else if (mode == vup_pkg::MODE_BOX) begin
        ax = vx.nx; ay = vx.ny; az = vx.nz;
        ax = ax < 0 ? -ax : ax; ay = ay < 0 ? -ay : ay; az = az < 0 ? -az : az;
        if (ax >= ay && ax >= az) begin
          u = z; v = y;
        end else if (ay >= az) begin
          u = x; v = z;
        end else begin
          u = x; v = y;
        end
      end
      pending_uv.push_back({scale_offset(v, off_v), scale_offset(u, off_u)});
    endfunction

    function void check_uv(logic [63:0] got);
      logic [63:0] want;
      if (pending_uv.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending_uv.pop_front();
      checked++;
      if (got[31:0] !== want[31:0] || got[63:32] !== want[63:32]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch #%0d: tex_u exp %h got %h, tex_v exp %h got %h",
                   checked, want[31:0], got[31:0], want[63:32], got[63:32]);
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [143:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [63:0]  m_tdata;
  logic         psel = 0, penable = 0, pwrite = 0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  uv_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  quiet_cycles  = 0;
  int  sent          = 0;

  vertex_uv_projection #(.CORDIC_STEPS(STEPS)) u_top (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // drive output back-pressure
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // check results and watch for a stall
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_uv(m_tdata);
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG) begin
      $display("watchdog expired, %0d results outstanding", sb.pending_uv.size());
      $display("** vertex_uv_projection: FAILED **");
      $finish;
    end
  end

  // one register write: setup then access; the caller drops the bus
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // hold the input idle until every expected result is back
  task automatic drain();
    s_tvalid <= 0;
    while (sb.pending_uv.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic configure(logic [1:0] mode, logic [31:0] scale, logic [31:0] ou,
                           logic [31:0] ov);
    drain();
    write_reg(vup_pkg::REG_MODE, {30'd0, mode});
    write_reg(vup_pkg::REG_SCALE, scale);
    write_reg(vup_pkg::REG_OFFSET_U, ou);
    write_reg(vup_pkg::REG_OFFSET_V, ov);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // offer one vertex request, hold it until accepted
  task automatic send_vertex(vertex_t vx);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= vx;
    do @(posedge clk); while (!s_tready);
    sb.note_vertex(vx);
    sent++;
  endtask

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(5))
      0: return $urandom_range(3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
      1: return 32'($signed($urandom_range(0, 2000)) - 1000);
      2: return 32'd0;
      default: return $urandom;
    endcase
  endfunction

  function automatic vertex_t rand_vertex();
    vertex_t vx;
    vx.x = rand_pos(); vx.y = rand_pos(); vx.z = rand_pos();
    vx.nx = 16'($urandom); vx.ny = 16'($urandom); vx.nz = 16'($urandom);
    // force normal ties now and then
    if ($urandom_range(7) == 0) vx.ny = vx.nx;
    if ($urandom_range(7) == 0) vx.nz = -vx.ny;
    if ($urandom_range(15) == 0) begin
      vx.x = 32'sd0; vx.y = 32'sd0; vx.z = 32'sd0;
    end
    return vx;
  endfunction

  task automatic random_burst(int n);
    repeat (n) send_vertex(rand_vertex());
  endtask

  initial begin
    vertex_t d;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: corners and special cases in every mode
    for (int m = 0; m < 4; m++) begin
      configure(m[1:0], 32'd65536, 32'd0, 32'd0);
      d = '{nz: 16'sd0, ny: 16'sd0, nx: 16'sh7fff, z: 32'sd0, y: 32'sd0, x: 32'sd0};
      send_vertex(d);                                          // zero length
      d = '{nz: 16'sh8000, ny: 16'sh8000, nx: 16'sh8000, z: 32'sd0,
            y: 32'sd65536, x: 32'sd0};
      send_vertex(d);                                          // pole, three-way tie
      d = '{nz: 16'sd5, ny: 16'sh7fff, nx: 16'sd1, z: 32'sh7fffffff,
            y: 32'sh80000000, x: 32'sh80000000};
      send_vertex(d);                                          // extremes
      d = '{nz: 16'sh7fff, ny: -16'sd9, nx: 16'sd9, z: -32'sd1,
            y: 32'sd3, x: -32'sd70000};
      send_vertex(d);                                          // negative x
      d = '{nz: 16'sd0, ny: 16'sd0, nx: 16'sd0, z: 32'sd0,
            y: 32'sd0, x: -32'sd65536};
      send_vertex(d);                                          // angle at +pi edge
    end
    // saturation and zero scale
    configure(vup_pkg::MODE_PLANAR, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
    send_vertex('{nz: 16'sd0, ny: 16'sd0, nx: 16'sd0, z: 32'sh80000000, y: 32'sd0,
                  x: 32'sh7fffffff});
    send_vertex('{nz: 16'sd0, ny: 16'sd0, nx: 16'sd0, z: 32'sh7fffffff, y: 32'sd0,
                  x: 32'sh80000000});
    configure(vup_pkg::MODE_SPHERE, 32'd0, 32'h1234_5678, 32'hdead_beef);
    send_vertex('{nz: 16'sd0, ny: 16'sd0, nx: 16'sd0, z: 32'sd7, y: 32'sd9,
                  x: 32'sd3});
    configure(vup_pkg::MODE_BOX, 32'd1, 32'h7fffffff, 32'h80000000);
    send_vertex('{nz: 16'sd3, ny: 16'sd2, nx: -16'sd3, z: 32'sd5, y: 32'sd6,
                  x: 32'sd7});

    // random phases under three idle profiles
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 67 : 0;
      recv_idle_pct = (ph == 0) ? 67 : (ph == 1) ? 31 : 0;
      for (int k = 0; k < 4; k++) begin
        configure(k == 3 ? 2'($urandom_range(3)) : k[1:0],
                  (k == 0) ? 32'd65536 : {1'b0, 31'($urandom)},
                  $urandom, $urandom);
        random_burst(150);
      end
    end

    drain();
    $display("sent %0d vertices, checked %0d results across planar, box, spherical", sent,
             sb.checked);
    $display("and mode-three settings with saturating scales and offsets");
    if (sb.mismatches == 0 && sb.pending_uv.size() == 0) begin
      $display("** vertex_uv_projection: PASSED **");
    end else begin
      $display("** vertex_uv_projection: FAILED **");
    end
    $finish;
  end

endmodule
